>>> sv/esps_pkg.sv
`timescale 1ns / 1ps

package esps_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_IMAGE_SIZE     = 3'd0;
    localparam logic [2:0] REG_BORDER_WIDTH   = 3'd1;
    localparam logic [2:0] REG_CFA_MASK       = 3'd2;
    localparam logic [2:0] REG_MAX_NORMAL     = 3'd3;
    localparam logic [2:0] REG_MAX_ALONG      = 3'd4;
    localparam logic [2:0] REG_EDGE_CENTROID  = 3'd5;
    localparam logic [2:0] REG_EDGE_NORMAL    = 3'd6;
    localparam logic [2:0] REG_EDGE_DIRECTION = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int LIMIT_W = 23;   // distance limits, 1/256 px
    localparam int DIST_W  = 24;   // signed distances, 1/256 px
    localparam int VALUE_W = 16;   // pixel value field
    localparam int DX_W    = 33;   // Q16.16 offset from centroid, signed
    localparam int PROD_W  = 48;   // Q16.16 x Q2.14 product, signed
    localparam int SUM_W   = 49;   // sum of two products
    localparam int RND_W   = 27;   // rounded magnitude, 1/256 px

    localparam logic [3:0] CFA_RESET = 4'hF;

    typedef struct packed {
        logic        [15:0]        cols;
        logic        [15:0]        rows;
        logic        [15:0]        border;
        logic        [3:0]         cfa;
        logic        [LIMIT_W-1:0] max_normal;
        logic        [LIMIT_W-1:0] max_along;
        logic        [31:0]        cx;
        logic        [31:0]        cy;
        logic signed [15:0]        nx;
        logic signed [15:0]        ny;
        logic signed [15:0]        ux;
        logic signed [15:0]        uy;
    } esps_cfg_t;

    // Pixel after selection and multiplication, waiting for the final stage
    typedef struct packed {
        logic                     sel;
        logic                     last;
        logic        [VALUE_W-1:0] value;
        logic signed [PROD_W-1:0] pnx;
        logic signed [PROD_W-1:0] pny;
        logic signed [PROD_W-1:0] pax;
        logic signed [PROD_W-1:0] pay;
    } esps_prod_t;

endpackage

>>> sv/esps_cfg.sv
`timescale 1ns / 1ps

module esps_cfg
    import esps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output esps_cfg_t             cfg
);

    esps_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            cfg_reg.cfa <= CFA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_SIZE: begin
                    cfg_reg.cols <= cfg_data[15:0];
                    cfg_reg.rows <= cfg_data[31:16];
                end
                REG_BORDER_WIDTH:  cfg_reg.border     <= cfg_data[15:0];
                REG_CFA_MASK:      cfg_reg.cfa        <= cfg_data[3:0];
                REG_MAX_NORMAL:    cfg_reg.max_normal <= cfg_data[LIMIT_W-1:0];
                REG_MAX_ALONG:     cfg_reg.max_along  <= cfg_data[LIMIT_W-1:0];
                REG_EDGE_CENTROID: begin
                    cfg_reg.cx <= cfg_data[31:0];
                    cfg_reg.cy <= cfg_data[63:32];
                end
                REG_EDGE_NORMAL: begin
                    cfg_reg.nx <= $signed(cfg_data[15:0]);
                    cfg_reg.ny <= $signed(cfg_data[31:16]);
                end
                REG_EDGE_DIRECTION: begin
                    cfg_reg.ux <= $signed(cfg_data[15:0]);
                    cfg_reg.uy <= $signed(cfg_data[31:16]);
                end
                default: ;
            endcase
        end
    end

endmodule

>>> sv/esps_proj.sv
`timescale 1ns / 1ps

module esps_proj
    import esps_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  esps_cfg_t    cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [15:0]  in_x,
    input  logic [15:0]  in_y,
    input  logic [15:0]  in_value,
    input  logic         in_last,
    output logic         prod_valid,
    input  logic         prod_ready,
    output esps_prod_t   prod
);

    logic                  pix_valid_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [PIXEL_BITS-1:0] value_reg;
    logic                  last_reg;

    logic                  prod_valid_reg;
    esps_prod_t            prod_reg;
    esps_prod_t            prod_next;

    logic                  prod_free;
    logic                  pix_free;
    logic [16:0]           x17, y17, bw17;
    logic                  in_window;
    logic [1:0]            site;
    logic signed [DX_W-1:0] dx, dy;

    assign prod_free = !prod_valid_reg || prod_ready;
    assign pix_free  = !pix_valid_reg || prod_free;
    assign in_ready  = pix_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else if (pix_free) begin
            pix_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_free && in_valid) begin
            x_reg     <= in_x[COORD_BITS-1:0];
            y_reg     <= in_y[COORD_BITS-1:0];
            value_reg <= in_value[PIXEL_BITS-1:0];
            last_reg  <= in_last;
        end
    end

    // Border window: x >= bw and x + bw < cols, same for rows
    assign x17  = 17'(x_reg);
    assign y17  = 17'(y_reg);
    assign bw17 = 17'(cfg.border);
    assign in_window = (x17 >= bw17) && (x17 + bw17 < 17'(cfg.cols)) &&
                       (y17 >= bw17) && (y17 + bw17 < 17'(cfg.rows));

    assign site = {y_reg[0], x_reg[0]} ^ 2'b11;

    // Offset from centroid in Q16.16
    assign dx = $signed((DX_W'(x_reg) << 16) - DX_W'(cfg.cx));
    assign dy = $signed((DX_W'(y_reg) << 16) - DX_W'(cfg.cy));

    always_comb begin
        prod_next.sel   = in_window && cfg.cfa[site];
        prod_next.last  = last_reg;
        prod_next.value = VALUE_W'(value_reg);
        prod_next.pnx   = dx * cfg.nx;
        prod_next.pny   = dy * cfg.ny;
        prod_next.pax   = dx * cfg.ux;
        prod_next.pay   = dy * cfg.uy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_free) begin
            prod_valid_reg <= pix_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_free && pix_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

>>> sv/esps_emit.sv
`timescale 1ns / 1ps

module esps_emit
    import esps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  esps_cfg_t           cfg,
    input  logic                prod_valid,
    output logic                prod_ready,
    input  esps_prod_t          prod,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_sample_valid,
    output logic [DIST_W-1:0]   out_sample_dist,
    output logic [VALUE_W-1:0]  out_sample_value,
    output logic                out_region_done,
    output logic [DIST_W-1:0]   out_region_span
);

    localparam logic signed [DIST_W-1:0] DIST_POS_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_NEG_MAX = {1'b1, {(DIST_W-1){1'b0}}};

    logic                       out_valid_reg;
    logic                       sample_valid_reg;
    logic [DIST_W-1:0]          sample_dist_reg;
    logic [VALUE_W-1:0]         sample_value_reg;
    logic                       region_done_reg;
    logic [DIST_W-1:0]          region_span_reg;

    logic signed [DIST_W-1:0]   along_min_reg, along_min_next;
    logic signed [DIST_W-1:0]   along_max_reg, along_max_next;
    logic                       any_kept_reg, any_kept_next;

    logic                       take;
    logic signed [SUM_W-1:0]    nsum, asum;
    logic                       nneg, aneg;
    logic [SUM_W-1:0]           nmag, amag;
    logic [RND_W-1:0]           nrnd, arnd;
    logic                       kept;
    logic signed [DIST_W-1:0]   perp, along;
    logic signed [DIST_W-1:0]   upd_min, upd_max;
    logic signed [DIST_W:0]     span;
    logic                       emit;

    assign take       = prod_valid && (!out_valid_reg || out_ready);
    assign prod_ready = !out_valid_reg || out_ready;

    // Round Q30 sums to 1/256 px, ties away from zero
    assign nsum = SUM_W'(prod.pnx) + SUM_W'(prod.pny);
    assign asum = SUM_W'(prod.pax) + SUM_W'(prod.pay);
    assign nneg = nsum[SUM_W-1];
    assign aneg = asum[SUM_W-1];
    assign nmag = nneg ? SUM_W'(-nsum) : SUM_W'(nsum);
    assign amag = aneg ? SUM_W'(-asum) : SUM_W'(asum);
    assign nrnd = RND_W'((nmag + (SUM_W'(1) << 21)) >> 22);
    assign arnd = RND_W'((amag + (SUM_W'(1) << 21)) >> 22);

    assign kept = prod.sel && (nrnd < RND_W'(cfg.max_normal)) &&
                  (arnd < RND_W'(cfg.max_along));

    // A kept distance is below a 23-bit limit, so it always fits the field
    assign perp  = nneg ? -$signed(DIST_W'(nrnd)) : $signed(DIST_W'(nrnd));
    assign along = aneg ? -$signed(DIST_W'(arnd)) : $signed(DIST_W'(arnd));

    assign upd_min = (kept && along < along_min_reg) ? along : along_min_reg;
    assign upd_max = (kept && along > along_max_reg) ? along : along_max_reg;
    assign span    = (DIST_W+1)'(upd_max) - (DIST_W+1)'(upd_min);
    assign emit    = kept || prod.last;

    always_comb begin
        if (prod.last) begin
            along_min_next = DIST_POS_MAX;
            along_max_next = DIST_NEG_MAX;
            any_kept_next  = 1'b0;
        end else begin
            along_min_next = upd_min;
            along_max_next = upd_max;
            any_kept_next  = any_kept_reg || kept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            along_min_reg <= DIST_POS_MAX;
            along_max_reg <= DIST_NEG_MAX;
            any_kept_reg  <= 1'b0;
        end else if (take) begin
            along_min_reg <= along_min_next;
            along_max_reg <= along_max_next;
            any_kept_reg  <= any_kept_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= emit;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            sample_valid_reg <= kept;
            sample_dist_reg  <= kept ? perp : '0;
            sample_value_reg <= kept ? prod.value : '0;
            region_done_reg  <= prod.last;
            region_span_reg  <= (prod.last && (any_kept_reg || kept)) ?
                                DIST_W'(span) : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_sample_valid = sample_valid_reg;
    assign out_sample_dist  = sample_dist_reg;
    assign out_sample_value = sample_value_reg;
    assign out_region_done  = region_done_reg;
    assign out_region_span  = region_span_reg;

endmodule

>>> sv/edge_spread_pixel_sampler_top.sv
`timescale 1ns / 1ps

// Edge spread sampler for slanted-edge measurement. Pixels stream in on the
// s_ channel in scan order, one request per pixel, with tlast on the final
// pixel of the edge region. Each pixel outside the border margin and on an
// enabled Bayer site is projected onto the edge normal and edge direction
// (centroid Q16.16, unit vectors Q2.14, distances rounded to 1/256 px, ties
// away from zero); if both distances are strictly inside their limits the
// pixel comes out on the m_ channel with its signed normal distance and
// value. The last pixel always produces a request carrying the edge length
// (max minus min along-edge distance of kept pixels, 0 if none) and clears
// the running min/max. Dropped pixels that are not last produce nothing.
// A result passes from the input register through the product register to the
// result register; one pixel is accepted every cycle while the output is not
// stalled, and a stalled output holds only the stages behind it, so bubbles
// in the pipeline still absorb new pixels. Write the configuration registers
// only while the block is idle.

module edge_spread_pixel_sampler_top
    import esps_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,  // pixel_x[15:0], pixel_y[31:16], pixel_value[47:32]
    input  logic                  s_tlast,  // last_pixel

    // Sample output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,  // sample_dist[23:0], sample_value[39:24],
                                            // region_span[63:40]
    output logic                  m_tuser,  // sample_valid
    output logic                  m_tlast   // region_done
);

    esps_cfg_t          cfg;
    esps_prod_t         prod;
    logic               prod_valid;
    logic               prod_ready;
    logic [DIST_W-1:0]  sample_dist;
    logic [VALUE_W-1:0] sample_value;
    logic [DIST_W-1:0]  region_span;

    // Register file: every write is taken at once
    esps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register, window and Bayer-site selection, the four products
    esps_proj #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_proj (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_x       (s_tdata[15:0]),
        .in_y       (s_tdata[31:16]),
        .in_value   (s_tdata[47:32]),
        .in_last    (s_tlast),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    // Rounding, limit check, running min/max and the result register
    esps_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .prod_valid       (prod_valid),
        .prod_ready       (prod_ready),
        .prod             (prod),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_sample_valid (m_tuser),
        .out_sample_dist  (sample_dist),
        .out_sample_value (sample_value),
        .out_region_done  (m_tlast),
        .out_region_span  (region_span)
    );

    assign m_tdata = {region_span, sample_value, sample_dist};

endmodule
